// ----- rtl/core/dqr_pkg.sv -----
package dqr_pkg;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int IDX_W = 4;
  localparam int AMT_W = 16;
  localparam int ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ       = 3'd4,
    REQ_ROTATE     = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// ----- rtl/core/deque_with_rotate_top.sv -----
// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// A request is taken when start is high and busy is low, and its result is
// shown for exactly one cycle with done high; the receiver cannot stall it.
// Pushes, pops, refused requests and unused codes finish in the execute state,
// and a read that finds its entry adds a wait state because of the registered
// memory read. A rotation first runs a 16-step serial remainder of the amount
// by the count and ends there when the amount is a multiple of the count.
// Otherwise one pass copies the entries into a scratch memory and a second
// pass writes them back in rotated order. Each pass moves one entry per cycle
// and then lets its last write drain.
module deque_with_rotate_top import dqr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [REQ_W-1:0]              req_type,
  input  logic signed [VAL_W-1:0]       push_value,
  input  logic [IDX_W-1:0]              read_index,
  input  logic [AMT_W-1:0]              rotate_amount,
  output logic                          done,
  output logic signed [VAL_W-1:0]       read_data,
  output logic [$clog2(DEPTH + 1)-1:0]  entry_count,
  output logic [ST_W-1:0]               status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_MOD, S_COPY, S_PLACE
  } state_t;

  state_t           state;
  req_t             req_q;
  logic [VAL_W-1:0] value_q;
  logic [IDX_W-1:0] idx_q;
  logic [AMT_W-1:0] amt_q;
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    walk;
  logic [AW-1:0]    j;
  logic             pend;
  logic [AW-1:0]    pend_addr;
  logic             rem_start;
  logic             rem_done;
  logic [CW-1:0]    rem;

  logic             full;
  logic             empty;
  logic             out_of_range;

  logic             ring_we;
  logic [AW-1:0]    ring_waddr;
  logic [VAL_W-1:0] ring_wdata;
  logic [AW-1:0]    ring_raddr;
  logic [VAL_W-1:0] ring_rdata;
  logic             scr_we;
  logic [VAL_W-1:0] scr_rdata;

  function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_slot(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [AW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, l};
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign busy         = (state != S_IDLE);
  assign full         = (count == CW'(DEPTH));
  assign empty        = (count == '0);
  assign out_of_range = (XW'(idx_q) >= XW'(count));

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = slot_of(head, AW'(count));
    ring_wdata = value_q;
    ring_raddr = slot_of(head, AW'(idx_q));
    if (state == S_EXEC && !full &&
        (req_q == REQ_PUSH_BACK || req_q == REQ_PUSH_FRONT)) begin
      ring_we = 1'b1;
      if (req_q == REQ_PUSH_FRONT) begin
        ring_waddr = dec_slot(head);
      end
    end
    if (state == S_PLACE) begin
      ring_we    = pend;
      ring_waddr = pend_addr;
      ring_wdata = scr_rdata;
    end
    if (state == S_COPY) begin
      ring_raddr = walk;
    end
    scr_we = (state == S_COPY) && pend;
  end

  dqr_ram #(.W(VAL_W), .D(DEPTH), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  dqr_ram #(.W(VAL_W), .D(DEPTH), .AW(AW)) u_scratch (
    .clk   (clk),
    .we    (scr_we),
    .waddr (pend_addr),
    .wdata (ring_rdata),
    .raddr (j),
    .rdata (scr_rdata)
  );

  dqr_rem #(.CW(CW)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (amt_q),
    .divisor   (count),
    .done      (rem_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      done      <= 1'b0;
      rem_start <= 1'b0;
      pend      <= 1'b0;
    end else begin
      done      <= 1'b0;
      rem_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_t'(req_type);
            value_q <= push_value;
            idx_q   <= read_index;
            amt_q   <= rotate_amount;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          read_data   <= '0;
          status      <= ST_OK;
          entry_count <= count;
          case (req_q)
            REQ_PUSH_BACK: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                count       <= count + 1'b1;
                entry_count <= count + 1'b1;
              end
            end
            REQ_PUSH_FRONT: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                head        <= dec_slot(head);
                count       <= count + 1'b1;
                entry_count <= count + 1'b1;
              end
            end
            REQ_POP_BACK: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                count       <= count - 1'b1;
                entry_count <= count - 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                head        <= inc_slot(head);
                count       <= count - 1'b1;
                entry_count <= count - 1'b1;
              end
            end
            REQ_READ: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else if (out_of_range) begin
                status <= ST_RANGE;
              end else begin
                done  <= 1'b0;
                state <= S_RDWAIT;
              end
            end
            REQ_ROTATE: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                done      <= 1'b0;
                rem_start <= 1'b1;
                state     <= S_MOD;
              end
            end
            default: begin
            end
          endcase
        end
        S_RDWAIT: begin
          read_data <= ring_rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_MOD: begin
          if (rem_done) begin
            if (rem == '0) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              cnt   <= '0;
              walk  <= head;
              pend  <= 1'b0;
              state <= S_COPY;
            end
          end
        end
        S_COPY: begin
          if (cnt < count) begin
            cnt       <= cnt + 1'b1;
            walk      <= inc_slot(walk);
            pend      <= 1'b1;
            pend_addr <= AW'(cnt);
          end else begin
            pend <= 1'b0;
          end
          if (cnt == count && !pend) begin
            cnt   <= '0;
            walk  <= head;
            j     <= AW'(count - rem);
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (cnt < count) begin
            cnt       <= cnt + 1'b1;
            walk      <= inc_slot(walk);
            j         <= (CW'(j) + 1'b1 == count) ? '0 : j + 1'b1;
            pend      <= 1'b1;
            pend_addr <= walk;
          end else begin
            pend <= 1'b0;
          end
          if (cnt == count && !pend) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/dqr_ram.sv -----
module dqr_ram #(
  parameter int W = 32,
  parameter int D = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dqr_rem.sv -----
module dqr_rem import dqr_pkg::*; #(
  parameter int CW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AMT_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             done,
  output logic [CW-1:0]    remainder
);

  localparam int SW = $clog2(AMT_W);

  logic             busy;
  logic [SW-1:0]    step;
  logic [AMT_W-1:0] quo;
  logic [CW:0]      trial;
  logic [CW-1:0]    rem_next;

  always_comb begin
    trial = {remainder, quo[AMT_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = CW'(trial - {1'b0, divisor});
    end else begin
      rem_next = CW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        quo       <= dividend;
        remainder <= '0;
        step      <= '0;
      end else if (busy) begin
        remainder <= rem_next;
        quo       <= quo << 1;
        step      <= step + 1'b1;
        if (step == SW'(AMT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/dqr_checker.sv -----
module dqr_checker import dqr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic signed [VAL_W-1:0] read_data,
  input logic [CW-1:0]           entry_count,
  input logic [ST_W-1:0]         status
);

  // Every result follows a cycle in which the block was working.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding busy cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CW'(DEPTH)))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CW'(DEPTH)))
    else $error("full status while not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_data == '0))
    else $error("nonzero data on a refused request");

endmodule

bind deque_with_rotate_top dqr_checker #(.DEPTH(DEPTH), .CW(CW)) u_dqr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .read_data   (read_data),
  .entry_count (entry_count),
  .status      (status)
);
